// File: hdl/four_by_four_matrix_mixer_clip_defines.svh
// assertion macros for the four by four matrix mixer
`ifndef FOUR_BY_FOUR_MATRIX_MIXER_CLIP_DEFINES_SVH
`define FOUR_BY_FOUR_MATRIX_MIXER_CLIP_DEFINES_SVH

`ifndef SYNTHESIS

// same cycle implication
`define MMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mixer check failed");

// next cycle implication
`define MMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mixer check failed");

`else

`define MMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/mmc_pkg.sv
// shared types, constants and fixed point helpers of the matrix mixer
package mmc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int CLIP_BITS   = 24;
    localparam int NUM_CH      = 4;
    localparam int NUM_BUS     = 4;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_BITS;
    localparam int SHIFT_W     = PROD_W - GAIN_FRAC;
    localparam int ACC_W       = SHIFT_W + $clog2(NUM_CH);
    localparam int CMP_W       = ((SAMPLE_BITS > CLIP_BITS) ? SAMPLE_BITS : CLIP_BITS) + 2;
    localparam int NUM_STAGES  = 7;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int MASTER_BITS    = 56;
    localparam int MUTE_BITS      = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIMS  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUTE0 = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUTE1 = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUTE2 = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUTE3 = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVELS = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASTER = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MUTES  = 4'd7;

    localparam logic [CFG_DATA_BITS-1:0] TRIMS_RESET  = 64'h1000_1000_1000_1000;
    localparam logic [CFG_DATA_BITS-1:0] ROUTE0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_BITS-1:0] ROUTE1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_BITS-1:0] ROUTE2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] ROUTE3_RESET = 64'h1000_0000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] LEVELS_RESET = 64'h1000_1000_1000_1000;
    localparam logic [MASTER_BITS-1:0]   MASTER_RESET = 56'h7F_FFFF_1000_1000;
    localparam logic [MUTE_BITS-1:0]     MUTES_RESET  = 8'h00;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [GAIN_BITS-1:0]   gain_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [NUM_STAGES-1:0]         stage_en_t;
    typedef prod_t [NUM_BUS-1:0]           lane_prod_t;

    localparam gain_t UNITY_GAIN = 16'sh1000;
    localparam acc_t  ACC_SMAX   = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam acc_t  ACC_SMIN   = acc_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef struct packed {
        gain_t                 trim;
        gain_t                 in_level;
        logic                  mute;
        gain_t [NUM_BUS-1:0]   route;
    } lane_cfg_t;

    typedef struct packed {
        gain_t [NUM_BUS-1:0]   post_gain;
        gain_t [NUM_BUS-1:0]   level;
        logic [CLIP_BITS-1:0]  clip;
        logic [NUM_BUS-1:0]    bus_mute;
    } merge_cfg_t;

    // floor of product / 4096, sign extended to accumulator width
    function automatic acc_t shift_ext(input prod_t p);
        logic signed [SHIFT_W-1:0] s;
        acc_t r;
        s = p[PROD_W-1:GAIN_FRAC];
        r = {{(ACC_W - SHIFT_W){s[SHIFT_W-1]}}, s};
        return r;
    endfunction

    function automatic sample_t sat(input acc_t v);
        sample_t r;
        if (v > ACC_SMAX) begin
            r = ACC_SMAX[SAMPLE_BITS-1:0];
        end else if (v < ACC_SMIN) begin
            r = ACC_SMIN[SAMPLE_BITS-1:0];
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic sample_t mulq_sat(input prod_t p);
        return sat(shift_ext(p));
    endfunction

endpackage

// File: hdl/mmc_lane.sv
// one input channel lane: trim, mute, input level and the four route products
module mmc_lane
    import mmc_pkg::*;
(
    input  logic       aclk,
    input  stage_en_t  stage_en,
    input  sample_t    sample,
    input  lane_cfg_t  cfg,
    output lane_prod_t route_prod
);

    prod_t      trim_prod_reg;
    prod_t      level_prod_reg;
    lane_prod_t route_prod_reg;

    gain_t   trim_g;
    gain_t   in_level_g;
    gain_t   route_g [NUM_BUS];
    sample_t trimmed;
    sample_t ch;

    always_comb begin
        trim_g     = cfg.trim;
        in_level_g = cfg.in_level;
        for (int b = 0; b < NUM_BUS; b++) begin
            route_g[b] = cfg.route[b];
        end
    end

    assign trimmed = cfg.mute ? '0 : mulq_sat(trim_prod_reg);
    assign ch      = mulq_sat(level_prod_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            trim_prod_reg <= prod_t'(sample) * prod_t'(trim_g);
        end
        if (stage_en[1]) begin
            level_prod_reg <= prod_t'(trimmed) * prod_t'(in_level_g);
        end
        if (stage_en[2]) begin
            for (int b = 0; b < NUM_BUS; b++) begin
                route_prod_reg[b] <= prod_t'(ch) * prod_t'(route_g[b]);
            end
        end
    end

    assign route_prod = route_prod_reg;

endmodule

// File: hdl/mmc_merge.sv
// bus merge: route sums, compensation, clip, mute and output level
module mmc_merge
    import mmc_pkg::*;
(
    input  logic       aclk,
    input  stage_en_t  stage_en,
    input  lane_prod_t lane_prod [NUM_CH],
    input  merge_cfg_t cfg,
    output sample_t    bus_out [NUM_BUS]
);

    sample_t          bus_reg        [NUM_BUS];
    prod_t            post_prod_reg  [NUM_BUS];
    prod_t            level_prod_reg [NUM_BUS];
    logic [NUM_BUS-1:0] mute_reg;
    sample_t          out_reg        [NUM_BUS];

    acc_t    acc       [NUM_BUS];
    gain_t   post_g    [NUM_BUS];
    gain_t   level_g   [NUM_BUS];
    sample_t post      [NUM_BUS];
    sample_t clipped   [NUM_BUS];
    logic signed [CMP_W-1:0] v_ext [NUM_BUS];
    logic signed [CMP_W-1:0] c_ext;
    logic signed [CMP_W-1:0] c_neg;
    logic signed [CMP_W-1:0] r_ext [NUM_BUS];

    always_comb begin
        c_ext = {{(CMP_W - CLIP_BITS){1'b0}}, cfg.clip};
        c_neg = -c_ext;
        for (int b = 0; b < NUM_BUS; b++) begin
            post_g[b]  = cfg.post_gain[b];
            level_g[b] = cfg.level[b];
            acc[b] = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                acc[b] = acc[b] + shift_ext(lane_prod[c][b]);
            end
            post[b]  = mulq_sat(post_prod_reg[b]);
            v_ext[b] = {{(CMP_W - SAMPLE_BITS){post[b][SAMPLE_BITS-1]}}, post[b]};
            if (v_ext[b] > c_ext) begin
                r_ext[b] = c_ext;
            end else if (v_ext[b] < c_neg) begin
                r_ext[b] = c_neg;
            end else begin
                r_ext[b] = v_ext[b];
            end
            clipped[b] = r_ext[b][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < NUM_BUS; b++) begin
            if (stage_en[3]) begin
                bus_reg[b] <= sat(acc[b]);
            end
            if (stage_en[4]) begin
                post_prod_reg[b] <= prod_t'(bus_reg[b]) * prod_t'(post_g[b]);
            end
            if (stage_en[5]) begin
                level_prod_reg[b] <= prod_t'(clipped[b]) * prod_t'(level_g[b]);
            end
            if (stage_en[6]) begin
                out_reg[b] <= mute_reg[b] ? '0 : mulq_sat(level_prod_reg[b]);
            end
        end
        if (stage_en[5]) begin
            mute_reg <= cfg.bus_mute;
        end
    end

    assign bus_out = out_reg;

endmodule

// File: hdl/four_by_four_matrix_mixer_clip.sv
// top level of the four by four matrix mixer with clip, mutes and levels
// Takes one frame of four signed samples per item and returns one frame of
// four bus samples. Four channel lanes compute trim, input mute and input
// level and the route products; a merge stage sums them into buses, applies
// compensation on the main buses, the symmetric clip, the mutes and the
// output levels. The datapath is a seven stage pipeline with at most one
// multiply per stage and path, so one item is accepted every clock while
// the output is not stalled; the result is presented from the last stage
// register. Each stage holds only while it is full and the stage after
// it is full and stalled. Both input and configuration ready are low during
// reset. Configuration is a write port with index and data; writes to an
// index beyond the register list are dropped.
`include "four_by_four_matrix_mixer_clip_defines.svh"

module four_by_four_matrix_mixer_clip
    import mmc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  sample_t                   s_in_sample0,
    input  sample_t                   s_in_sample1,
    input  sample_t                   s_in_sample2,
    input  sample_t                   s_in_sample3,

    output logic                      m_valid,
    input  logic                      m_ready,
    output sample_t                   m_main_right,
    output sample_t                   m_main_left,
    output sample_t                   m_aux_left,
    output sample_t                   m_aux_right,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [CFG_DATA_BITS-1:0] trims_reg;
    logic [CFG_DATA_BITS-1:0] route_reg [NUM_BUS];
    logic [CFG_DATA_BITS-1:0] levels_reg;
    logic [MASTER_BITS-1:0]   master_reg;
    logic [MUTE_BITS-1:0]     mutes_reg;
    logic [NUM_STAGES-1:0]    vld_reg;

    stage_en_t  stage_en;
    sample_t    samples   [NUM_CH];
    lane_cfg_t  lane_cfg  [NUM_CH];
    lane_prod_t lane_prod [NUM_CH];
    merge_cfg_t merge_cfg;
    sample_t    bus_out   [NUM_BUS];
    logic       main_mute;

    // config registers
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trims_reg    <= TRIMS_RESET;
            route_reg[0] <= ROUTE0_RESET;
            route_reg[1] <= ROUTE1_RESET;
            route_reg[2] <= ROUTE2_RESET;
            route_reg[3] <= ROUTE3_RESET;
            levels_reg   <= LEVELS_RESET;
            master_reg   <= MASTER_RESET;
            mutes_reg    <= MUTES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TRIMS:  trims_reg    <= cfg_data;
                REG_ROUTE0: route_reg[0] <= cfg_data;
                REG_ROUTE1: route_reg[1] <= cfg_data;
                REG_ROUTE2: route_reg[2] <= cfg_data;
                REG_ROUTE3: route_reg[3] <= cfg_data;
                REG_LEVELS: levels_reg   <= cfg_data;
                REG_MASTER: master_reg   <= cfg_data[MASTER_BITS-1:0];
                REG_MUTES:  mutes_reg    <= cfg_data[MUTE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage enables, each stage moves when empty or when the next one moves
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = aresetn && stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // lane config
    assign samples[0] = s_in_sample0;
    assign samples[1] = s_in_sample1;
    assign samples[2] = s_in_sample2;
    assign samples[3] = s_in_sample3;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            lane_cfg[c].trim     = trims_reg[GAIN_BITS*c +: GAIN_BITS];
            lane_cfg[c].in_level = master_reg[GAIN_BITS-1:0];
            lane_cfg[c].mute     = mutes_reg[c];
            for (int b = 0; b < NUM_BUS; b++) begin
                lane_cfg[c].route[b] = route_reg[b][GAIN_BITS*c +: GAIN_BITS];
            end
        end
    end

    // merge config
    assign main_mute = mutes_reg[4] | mutes_reg[5];

    always_comb begin
        for (int b = 0; b < NUM_BUS; b++) begin
            merge_cfg.level[b] = levels_reg[GAIN_BITS*b +: GAIN_BITS];
        end
        merge_cfg.post_gain[0] = master_reg[2*GAIN_BITS-1:GAIN_BITS];
        merge_cfg.post_gain[1] = master_reg[2*GAIN_BITS-1:GAIN_BITS];
        merge_cfg.post_gain[2] = UNITY_GAIN;
        merge_cfg.post_gain[3] = UNITY_GAIN;
        merge_cfg.clip         = master_reg[2*GAIN_BITS +: CLIP_BITS];
        merge_cfg.bus_mute     = {mutes_reg[7], mutes_reg[6], main_mute, main_mute};
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        mmc_lane u_lane (
            .aclk       (aclk),
            .stage_en   (stage_en),
            .sample     (samples[c]),
            .cfg        (lane_cfg[c]),
            .route_prod (lane_prod[c])
        );
    end

    mmc_merge u_merge (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .lane_prod (lane_prod),
        .cfg       (merge_cfg),
        .bus_out   (bus_out)
    );

    assign m_main_right = bus_out[0];
    assign m_main_left  = bus_out[1];
    assign m_aux_left   = bus_out[2];
    assign m_aux_right  = bus_out[3];

    // checks
    `MMC_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    `MMC_ASSERT_NEXT(a_last_moves, aclk, aresetn, vld_reg[NUM_STAGES-2] && !(m_valid && !m_ready), m_valid)

endmodule

// File: sim/mixer_checker.sv
`timescale 1ns / 1ps
// scoreboard for the matrix mixer: predicts every output frame and compares it field by field
module mixer_checker
    import mmc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  sample_t                   s_in_sample0,
    input  sample_t                   s_in_sample1,
    input  sample_t                   s_in_sample2,
    input  sample_t                   s_in_sample3,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  sample_t                   m_main_right,
    input  sample_t                   m_main_left,
    input  sample_t                   m_aux_left,
    input  sample_t                   m_aux_right,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        frames_checked
);

    localparam int     NUM_REGS = int'(REG_MUTES) + 1;
    localparam longint SMAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    typedef struct {
        sample_t main_right;
        sample_t main_left;
        sample_t aux_left;
        sample_t aux_right;
    } mix_frame_t;

    logic [CFG_DATA_BITS-1:0] mix_regs [NUM_REGS];
    mix_frame_t               expected_frames [$];
    mix_frame_t               want;

    initial begin
        fail_count     = 0;
        frames_checked = 0;
        outstanding    = 0;
    end

    function automatic logic [CFG_DATA_BITS-1:0] reg_mask(input logic [CFG_INDEX_BITS-1:0] idx);
        case (idx)
            REG_MASTER: return 64'h00FF_FFFF_FFFF_FFFF;
            REG_MUTES:  return 64'h0000_0000_0000_00FF;
            default:    return '1;
        endcase
    endfunction

    function automatic longint gain_of(input logic [CFG_DATA_BITS-1:0] word, input int slot);
        gain_t g;
        g = word[16*slot +: 16];
        return longint'(g);
    endfunction

    function automatic longint scale_q(input longint a, input longint g);
        return (a * g) >>> GAIN_FRAC;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > SMAX) return SMAX;
        if (v < -SMAX - 1) return -SMAX - 1;
        return v;
    endfunction

    function automatic mix_frame_t mix_predict(input sample_t s0, input sample_t s1,
                                               input sample_t s2, input sample_t s3);
        longint                   smp [NUM_CH];
        longint                   ch [NUM_CH];
        longint                   bus [NUM_BUS];
        longint                   acc;
        longint                   x;
        longint                   clip;
        longint                   in_level;
        longint                   comp;
        logic [CFG_DATA_BITS-1:0] master;
        logic [CFG_DATA_BITS-1:0] mutes;
        logic                     muted;
        mix_frame_t               r;
        smp[0]   = s0;
        smp[1]   = s1;
        smp[2]   = s2;
        smp[3]   = s3;
        master   = mix_regs[REG_MASTER];
        mutes    = mix_regs[REG_MUTES];
        in_level = gain_of(master, 0);
        comp     = gain_of(master, 1);
        clip     = longint'(master[55:32]);
        for (int c = 0; c < NUM_CH; c++) begin
            x = clamp_sample(scale_q(smp[c], gain_of(mix_regs[REG_TRIMS], c)));
            if (mutes[c]) x = 0;
            ch[c] = clamp_sample(scale_q(x, in_level));
        end
        for (int b = 0; b < NUM_BUS; b++) begin
            acc = 0;
            for (int c = 0; c < NUM_CH; c++) begin
                acc += scale_q(ch[c], gain_of(mix_regs[int'(REG_ROUTE0) + b], c));
            end
            bus[b] = clamp_sample(acc);
        end
        bus[0] = clamp_sample(scale_q(bus[0], comp));
        bus[1] = clamp_sample(scale_q(bus[1], comp));
        for (int b = 0; b < NUM_BUS; b++) begin
            if (bus[b] > clip) bus[b] = clip;
            if (bus[b] < -clip) bus[b] = -clip;
            muted = (b < 2) ? (mutes[4] | mutes[5]) : mutes[4 + b];
            if (muted) bus[b] = 0;
            else bus[b] = clamp_sample(scale_q(bus[b], gain_of(mix_regs[REG_LEVELS], b)));
        end
        r.main_right = sample_t'(bus[0]);
        r.main_left  = sample_t'(bus[1]);
        r.aux_left   = sample_t'(bus[2]);
        r.aux_right  = sample_t'(bus[3]);
        return r;
    endfunction

    task automatic check_field(input string name, input sample_t exp_v, input sample_t act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mix_regs[REG_TRIMS]  = TRIMS_RESET;
            mix_regs[REG_ROUTE0] = ROUTE0_RESET;
            mix_regs[REG_ROUTE1] = ROUTE1_RESET;
            mix_regs[REG_ROUTE2] = ROUTE2_RESET;
            mix_regs[REG_ROUTE3] = ROUTE3_RESET;
            mix_regs[REG_LEVELS] = LEVELS_RESET;
            mix_regs[REG_MASTER] = 64'(MASTER_RESET);
            mix_regs[REG_MUTES]  = 64'(MUTES_RESET);
            expected_frames.delete();
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_frames.push_back(mix_predict(s_in_sample0, s_in_sample1,
                                                      s_in_sample2, s_in_sample3));
            end
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("output item with no expectation: %0d %0d %0d %0d",
                           m_main_right, m_main_left, m_aux_left, m_aux_right);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("main_right", want.main_right, m_main_right);
                    check_field("main_left", want.main_left, m_main_left);
                    check_field("aux_left", want.aux_left, m_aux_left);
                    check_field("aux_right", want.aux_right, m_aux_right);
                    frames_checked++;
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
                mix_regs[cfg_index] = cfg_data & reg_mask(cfg_index);
            end
            outstanding <= expected_frames.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// top of the matrix mixer testbench: clock, reset, stimulus, settings and verdict
module tb;
    import mmc_pkg::*;

    localparam int      NUM_REGS      = int'(REG_MUTES) + 1;
    localparam int      SETTLE        = NUM_STAGES + 4;
    localparam int      STALL_LIMIT   = 4000;
    localparam int      RANDOM_FRAMES = 1900;
    localparam sample_t S_MAX         = 24'sh7FFFFF;
    localparam sample_t S_MIN         = 24'sh800000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    sample_t                   s_in_sample0;
    sample_t                   s_in_sample1;
    sample_t                   s_in_sample2;
    sample_t                   s_in_sample3;
    logic                      m_valid;
    logic                      m_ready;
    sample_t                   m_main_right;
    sample_t                   m_main_left;
    sample_t                   m_aux_left;
    sample_t                   m_aux_right;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int                        fail_count;
    int                        outstanding;
    int                        frames_checked;
    int                        idle_cycles = 0;
    int                        reg_writes = 0;
    int                        settings_used = 0;
    int                        frames_sent = 0;
    bit                        quiet = 1'b0;
    logic [CFG_DATA_BITS-1:0]  plan [NUM_REGS];

    four_by_four_matrix_mixer_clip uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample0 (s_in_sample0),
        .s_in_sample1 (s_in_sample1),
        .s_in_sample2 (s_in_sample2),
        .s_in_sample3 (s_in_sample3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_main_right (m_main_right),
        .m_main_left  (m_main_left),
        .m_aux_left   (m_aux_left),
        .m_aux_right  (m_aux_right),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mixer_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_sample0   (s_in_sample0),
        .s_in_sample1   (s_in_sample1),
        .s_in_sample2   (s_in_sample2),
        .s_in_sample3   (s_in_sample3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_main_right   (m_main_right),
        .m_main_left    (m_main_left),
        .m_aux_left     (m_aux_left),
        .m_aux_right    (m_aux_right),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .frames_checked (frames_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return sample_t'($signed($urandom_range(0, 8191)) - 4096);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic gain_t rand_gain();
        case ($urandom_range(0, 9))
            0:       return UNITY_GAIN;
            1:       return 16'sh7FFF;
            2:       return 16'sh8000;
            3:       return 16'sh0000;
            4:       return 16'shF000;
            5, 6:    return gain_t'($signed($urandom_range(0, 16'h4000)) - 16'sh2000);
            default: return gain_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_gain_word();
        return {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
    endfunction

    function automatic logic [CLIP_BITS-1:0] rand_clip();
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h7FFFFF;
            3:       return 24'h800000;
            4:       return 24'($urandom_range(0, 65535));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_frame(input sample_t x0, input sample_t x1,
                              input sample_t x2, input sample_t x3);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_sample0 <= x0;
        s_in_sample1 <= x1;
        s_in_sample2 <= x2;
        s_in_sample3 <= x3;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        frames_sent++;
    endtask

    task automatic push_random_frame();
        push_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic drain_frames();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        reg_writes++;
    endtask

    task automatic commit_plan(input bit junk);
        drain_frames();
        for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_INDEX_BITS'(i), plan[i]);
        if (junk || $urandom_range(0, 2) == 0) begin
            write_reg(CFG_INDEX_BITS'(NUM_REGS + $urandom_range(0, 15 - NUM_REGS)),
                      {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        settings_used++;
    endtask

    task automatic reset_plan();
        plan[REG_TRIMS]  = TRIMS_RESET;
        plan[REG_ROUTE0] = ROUTE0_RESET;
        plan[REG_ROUTE1] = ROUTE1_RESET;
        plan[REG_ROUTE2] = ROUTE2_RESET;
        plan[REG_ROUTE3] = ROUTE3_RESET;
        plan[REG_LEVELS] = LEVELS_RESET;
        plan[REG_MASTER] = 64'(MASTER_RESET);
        plan[REG_MUTES]  = 64'(MUTES_RESET);
    endtask

    task automatic random_plan();
        if ($urandom_range(0, 7) == 0) begin
            reset_plan();
        end else begin
            for (int i = int'(REG_TRIMS); i <= int'(REG_LEVELS); i++) plan[i] = rand_gain_word();
            plan[REG_MASTER] = {8'($urandom), rand_clip(), rand_gain(), rand_gain()};
            plan[REG_MUTES]  = {56'({$urandom, $urandom}),
                                ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00};
        end
    endtask

    initial begin
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] mute_cases [5];
        int         target;
        int         n;
        mute_cases   = '{8'h0F, 8'h10, 8'h20, 8'hC0, 8'h35};
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_in_sample0 <= '0;
        s_in_sample1 <= '0;
        s_in_sample2 <= '0;
        s_in_sample3 <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, sample extremes and bit patterns
        push_frame(24'sd0, 24'sd0, 24'sd0, 24'sd0);
        push_frame(S_MAX, S_MAX, S_MAX, S_MAX);
        push_frame(S_MIN, S_MIN, S_MIN, S_MIN);
        push_frame(-24'sd1, -24'sd1, -24'sd1, -24'sd1);
        push_frame(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
        push_frame(24'sd1, S_MIN, S_MAX, -24'sd1);

        // all gains at maximum, clip open beyond sample range
        plan[REG_TRIMS]  = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_ROUTE0] = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_ROUTE1] = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_ROUTE2] = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_ROUTE3] = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_LEVELS] = 64'h7FFF_7FFF_7FFF_7FFF;
        plan[REG_MASTER] = {8'hA5, 24'hFFFFFF, 16'h7FFF, 16'h7FFF};
        plan[REG_MUTES]  = 64'hFFFF_FFFF_FFFF_FF00;
        commit_plan(1'b1);
        push_frame(S_MAX, S_MAX, S_MAX, S_MAX);
        push_frame(S_MIN, S_MIN, S_MIN, S_MIN);
        push_frame(S_MAX, S_MIN, 24'sd1, -24'sd1);

        // most negative gains everywhere
        plan[REG_TRIMS]  = 64'h8000_8000_8000_8000;
        plan[REG_ROUTE0] = 64'h8000_8000_8000_8000;
        plan[REG_ROUTE1] = 64'h8000_8000_8000_8000;
        plan[REG_ROUTE2] = 64'h8000_8000_8000_8000;
        plan[REG_ROUTE3] = 64'h8000_8000_8000_8000;
        plan[REG_LEVELS] = 64'h8000_8000_8000_8000;
        plan[REG_MASTER] = {8'h00, 24'h7FFFFF, 16'h8000, 16'h8000};
        plan[REG_MUTES]  = 64'h0;
        commit_plan(1'b0);
        push_frame(S_MAX, S_MAX, S_MAX, S_MAX);
        push_frame(S_MIN, S_MIN, S_MIN, S_MIN);

        // clip magnitude zero
        reset_plan();
        plan[REG_MASTER] = {8'h00, 24'h000000, 16'h1000, 16'h1000};
        commit_plan(1'b0);
        push_frame(S_MAX, S_MAX, S_MAX, S_MAX);
        push_frame(S_MIN, S_MAX, 24'sd1234, -24'sd5678);

        // mixed signed routes, clip just past full scale, each mute flag
        reset_plan();
        plan[REG_ROUTE0] = 64'hF000_0800_0400_1000;
        plan[REG_ROUTE1] = 64'h0400_F800_1000_C000;
        plan[REG_ROUTE2] = 64'h1000_1000_F000_0800;
        plan[REG_ROUTE3] = 64'h2000_0001_FFFF_1000;
        plan[REG_MASTER] = {8'h00, 24'h800000, 16'h1800, 16'h0C00};
        for (int i = 0; i < 5; i++) begin
            plan[REG_MUTES] = {56'hFF_FFFF_FFFF_FFFF, mute_cases[i]};
            commit_plan(1'b0);
            push_random_frame();
        end

        target = frames_sent + RANDOM_FRAMES;
        while (frames_sent < target) begin
            random_plan();
            commit_plan(1'b0);
            quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(80, 240);
            if (n > target - frames_sent) n = target - frames_sent;
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && $urandom_range(0, 1) == 0) drain_frames();
                push_random_frame();
            end
        end

        drain_frames();
        $display("mixer run: %0d frames checked across %0d settings, %0d register writes",
                 frames_checked, settings_used, reg_writes);
        $display("included saturating and negative gains, zero and open clip, all mute flags");
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
